[hdl/ra_pkg.sv]
// ra_pkg: beat types, codes and control structs for the rational accumulator
// used by ra_ctrl, ra_dp and rational_accumulator; no dependencies
package ra_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] operand_num;
        logic signed [31:0] operand_den;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic [1:0]         status;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL_A, S_MUL_B, S_MUL_D, S_SUM, S_GCD, S_DIV, S_FIN
    } t_state;

    typedef enum logic [1:0] {PR_FIRST, PR_SECOND, PR_DEN} t_prod;

    typedef enum logic [1:0] {FIN_ERR, FIN_ZERO, FIN_CALC} t_fin;

    typedef struct packed {
        logic  capture;
        logic  mul;
        t_prod prod;
        logic  load;
        logic  gcd_step;
        logic  div_init;
        logic  div_step;
        logic  finish;
        t_fin  fin;
    } t_ctl;

    typedef struct packed {
        logic err;
        logic num_zero;
        logic gcd_eq;
        logic div_last;
    } t_sts;

endpackage

[hdl/ra_ctrl.sv]
// ra_ctrl: sequencing state machine for the rational accumulator
// depends on ra_pkg
module ra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    input  ra_pkg::t_sts  i_sts,
    output ra_pkg::t_ctl  o_ctl,
    output logic          o_in_stall
);
    import ra_pkg::*;

    t_state r_state, n_state;
    t_fin   r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= FIN_ERR;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                if (i_sts.err) begin
                    n_fin   = FIN_ERR;
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: n_state = S_MUL_B;
            S_MUL_B: n_state = S_MUL_D;
            S_MUL_D: n_state = S_SUM;
            S_SUM: begin
                if (i_sts.num_zero) begin
                    n_fin   = FIN_ZERO;
                    n_state = S_FIN;
                end else begin
                    n_fin   = FIN_CALC;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_eq) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl          = '0;
        o_ctl.prod     = PR_FIRST;
        o_ctl.fin      = r_fin;
        o_in_stall     = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:  o_ctl.capture = i_in_valid;
            S_MUL_A: begin
                o_ctl.mul  = 1'b1;
                o_ctl.prod = PR_FIRST;
            end
            S_MUL_B: begin
                o_ctl.mul  = 1'b1;
                o_ctl.prod = PR_SECOND;
            end
            S_MUL_D: begin
                o_ctl.mul  = 1'b1;
                o_ctl.prod = PR_DEN;
            end
            S_SUM:   o_ctl.load = 1'b1;
            S_GCD: begin
                o_ctl.gcd_step = !i_sts.gcd_eq;
                o_ctl.div_init = i_sts.gcd_eq;
            end
            S_DIV:   o_ctl.div_step = 1'b1;
            S_FIN:   o_ctl.finish = i_out_free;
            default: o_ctl.capture = 1'b0;
        endcase
    end

endmodule

[hdl/ra_dp.sv]
// ra_dp: accumulator registers, shared multiplier, binary gcd and dividers
// depends on ra_pkg; driven by ra_ctrl
module ra_dp #(
    parameter int VALUE_WIDTH = ra_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ra_pkg::t_ctl      i_ctl,
    input  ra_pkg::t_in_beat  i_in,
    output ra_pkg::t_sts      o_sts,
    output ra_pkg::t_out_beat o_out
);
    import ra_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int DW = 2 * W;
    localparam int CW = $clog2(DW);
    localparam int SW = $clog2(DW) + 1;
    localparam logic [DW-1:0] POS_LIM = (DW'(1) << (W - 1)) - DW'(1);
    localparam logic [DW-1:0] NEG_LIM = DW'(1) << (W - 1);

    logic [1:0]           r_cmd;
    logic signed [W:0]    r_c, r_e;
    logic signed [W-1:0]  r_acc_num, n_acc_num;
    logic [W-2:0]         r_acc_den, n_acc_den;
    logic signed [PW-1:0] r_pa, r_pb, r_pd;
    logic [DW-1:0]        r_mag, r_den, r_ga, r_gb, r_g, r_q1, r_q2;
    logic                 r_neg;
    logic [SW-1:0]        r_sh;
    logic [DW:0]          r_rem1, r_rem2;
    logic [CW-1:0]        r_cnt;
    t_out_beat            r_out;

    logic signed [W-1:0]  w_cn, w_en;
    logic signed [W:0]    w_c, w_e, w_a, w_b, w_mx, w_my;
    logic signed [PW-1:0] w_p, w_dn;
    logic signed [PW:0]   w_s;
    logic [DW-1:0]        w_mag;
    logic [DW:0]          w_t1, w_t2;
    logic                 w_ovf;
    logic [1:0]           w_status;

    assign w_cn = i_in.operand_num[W-1:0];
    assign w_en = i_in.operand_den[W-1:0];
    assign w_a  = (W+1)'(r_acc_num);
    assign w_b  = signed'({2'b00, r_acc_den});

    always_comb begin
        w_c = (W+1)'(w_cn);
        w_e = (W+1)'(w_en);
        if (w_e[W]) begin
            w_c = -w_c;
            w_e = -w_e;
        end
    end

    always_comb begin
        case (i_ctl.prod)
            PR_FIRST: begin
                w_mx = w_a;
                w_my = (r_cmd == CMD_MUL) ? r_c : r_e;
            end
            PR_SECOND: begin
                w_mx = r_c;
                w_my = w_b;
            end
            PR_DEN: begin
                w_mx = w_b;
                w_my = (r_cmd == CMD_DIV) ? r_c : r_e;
            end
            default: begin
                w_mx = w_a;
                w_my = r_e;
            end
        endcase
        w_p = w_mx * w_my;
    end

    always_comb begin
        case (r_cmd)
            CMD_ADD: w_s = (PW+1)'(r_pa) + (PW+1)'(r_pb);
            CMD_SUB: w_s = (PW+1)'(r_pa) - (PW+1)'(r_pb);
            default: w_s = (PW+1)'(r_pa);
        endcase
        w_dn = r_pd;
        if (r_cmd == CMD_DIV && r_c[W]) begin
            w_s  = -w_s;
            w_dn = -r_pd;
        end
        w_mag = w_s[PW] ? DW'(-w_s) : DW'(w_s);
    end

    assign w_t1 = {r_rem1[DW-1:0], r_q1[DW-1]};
    assign w_t2 = {r_rem2[DW-1:0], r_q2[DW-1]};

    assign o_sts.err      = (r_e == '0) || (r_cmd == CMD_DIV && r_c == '0);
    assign o_sts.num_zero = (w_s == '0);
    assign o_sts.gcd_eq   = (r_ga == r_gb);
    assign o_sts.div_last = (r_cnt == CW'(DW - 1));

    always_comb begin
        w_ovf = (r_q2 > POS_LIM) || (r_neg ? (r_q1 > NEG_LIM) : (r_q1 > POS_LIM));
        n_acc_num = r_acc_num;
        n_acc_den = r_acc_den;
        w_status  = ST_OK;
        case (i_ctl.fin)
            FIN_ERR:  w_status = ST_DIVZ;
            FIN_ZERO: begin
                n_acc_num = '0;
                n_acc_den = (W-1)'(1);
            end
            FIN_CALC: begin
                if (w_ovf) begin
                    w_status = ST_OVF;
                end else begin
                    n_acc_num = r_neg ? -signed'(r_q1[W-1:0]) : signed'(r_q1[W-1:0]);
                    n_acc_den = r_q2[W-2:0];
                end
            end
            default:  w_status = ST_DIVZ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_num <= '0;
            r_acc_den <= (W-1)'(1);
        end else if (i_ctl.finish) begin
            r_acc_num <= n_acc_num;
            r_acc_den <= n_acc_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_in.cmd;
            r_c   <= w_c;
            r_e   <= w_e;
        end
        if (i_ctl.mul) begin
            case (i_ctl.prod)
                PR_FIRST:  r_pa <= w_p;
                PR_SECOND: r_pb <= w_p;
                PR_DEN:    r_pd <= w_p;
                default:   r_pa <= w_p;
            endcase
        end
        if (i_ctl.load) begin
            r_mag <= w_mag;
            r_den <= DW'(w_dn);
            r_neg <= w_s[PW];
            r_ga  <= w_mag;
            r_gb  <= DW'(w_dn);
            r_sh  <= '0;
        end
        if (i_ctl.gcd_step) begin
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_sh <= r_sh + SW'(1);
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga > r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_ctl.div_init) begin
            r_g    <= r_ga << r_sh;
            r_q1   <= r_mag;
            r_q2   <= r_den;
            r_rem1 <= '0;
            r_rem2 <= '0;
            r_cnt  <= '0;
        end
        if (i_ctl.div_step) begin
            r_cnt <= r_cnt + CW'(1);
            if (w_t1 >= {1'b0, r_g}) begin
                r_rem1 <= w_t1 - {1'b0, r_g};
                r_q1   <= {r_q1[DW-2:0], 1'b1};
            end else begin
                r_rem1 <= w_t1;
                r_q1   <= {r_q1[DW-2:0], 1'b0};
            end
            if (w_t2 >= {1'b0, r_g}) begin
                r_rem2 <= w_t2 - {1'b0, r_g};
                r_q2   <= {r_q2[DW-2:0], 1'b1};
            end else begin
                r_rem2 <= w_t2;
                r_q2   <= {r_q2[DW-2:0], 1'b0};
            end
        end
        if (i_ctl.finish) begin
            r_out.result_num <= 32'(n_acc_num);
            r_out.result_den <= 31'(n_acc_den);
            r_out.status     <= w_status;
        end
    end

    assign o_out = r_out;

endmodule

[hdl/rational_accumulator.sv]
// rational_accumulator: one beat in, one beat out per operation
// sequence: capture, operand check, three multiplier products, sum, gcd loop, dividers, finish;
// a zero denominator or divide by zero goes to finish after the check, a zero result after the sum
// throughput: one operation at a time, next beat taken the cycle after the result is written;
// the gcd loop, the bit-serial dividers and a stalled output set it
// reset: accumulator 0/1, no beat pending; output register lets the next beat start
module rational_accumulator #(
    parameter int VALUE_WIDTH = ra_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ra_pkg::t_in_beat  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ra_pkg::t_out_beat o_out_data
);
    import ra_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic r_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    ra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_in_stall (o_in_stall)
    );

    ra_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_in    (i_in_data),
        .o_sts   (w_sts),
        .o_out   (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.result_den != '0)
        else $error("result denominator is zero");

    a_zero_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_num == '0) |-> o_out_data.result_den == 31'd1)
        else $error("zero result not reduced to 0/1");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat accepted while busy");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.finish |-> w_out_free)
        else $error("result written over a pending beat");

endmodule
